>>> src/shc_pkg.sv
package shc_pkg;

  localparam int unsigned CHAIN_DEPTH      = 128;
  localparam int unsigned MAX_RECORD_BYTES = 256;
  localparam int unsigned HDR_BYTES        = 44;
  localparam int unsigned GEN_BYTES        = 7;

  localparam int unsigned CNT_W = $clog2(CHAIN_DEPTH + 1);
  localparam int unsigned LEN_W = $clog2(MAX_RECORD_BYTES + 1);
  localparam int unsigned TOT_W = $clog2(HDR_BYTES + MAX_RECORD_BYTES + GEN_BYTES + 1);

  typedef enum logic [1:0] {
    OP_INIT  = 2'd0,
    OP_BYTE  = 2'd1,
    OP_EMPTY = 2'd2,
    OP_NONE  = 2'd3
  } op_e;

  typedef logic [15:0][31:0] blk_t;
  typedef logic [7:0][31:0]  hash_t;

  localparam logic [31:0] SHA_K [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  localparam logic [31:0] SHA_IV [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [7:0] GEN_TEXT [GEN_BYTES] = '{
    8'h47, 8'h45, 8'h4e, 8'h45, 8'h53, 8'h49, 8'h53
  };

endpackage

>>> src/shc_core.sv
module shc_core (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          init_i,
  input  logic          start_i,
  input  shc_pkg::blk_t blk_i,
  output logic          done_o,
  output shc_pkg::hash_t hash_o
);
  import shc_pkg::*;

  hash_t       h_q;
  hash_t       v_q;
  blk_t        win_q;
  logic        run_q, add_q;
  logic [5:0]  rnd_q;
  logic [31:0] e1, ch, t1, a0, mj, s0, s1, wnew;

  always_comb begin
    e1   = {v_q[4][5:0], v_q[4][31:6]} ^ {v_q[4][10:0], v_q[4][31:11]}
         ^ {v_q[4][24:0], v_q[4][31:25]};
    ch   = (v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6]);
    t1   = v_q[7] + e1 + ch + SHA_K[rnd_q] + win_q[0];
    a0   = {v_q[0][1:0], v_q[0][31:2]} ^ {v_q[0][12:0], v_q[0][31:13]}
         ^ {v_q[0][21:0], v_q[0][31:22]};
    mj   = (v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]);
    s0   = {win_q[1][6:0], win_q[1][31:7]} ^ {win_q[1][17:0], win_q[1][31:18]}
         ^ (win_q[1] >> 3);
    s1   = {win_q[14][16:0], win_q[14][31:17]} ^ {win_q[14][18:0], win_q[14][31:19]}
         ^ (win_q[14] >> 10);
    wnew = win_q[0] + s0 + win_q[9] + s1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q <= 1'b0;
      add_q <= 1'b0;
      rnd_q <= '0;
      for (int i = 0; i < 8; i++) h_q[i] <= SHA_IV[i];
    end else begin
      add_q <= 1'b0;
      if (init_i) begin
        for (int i = 0; i < 8; i++) h_q[i] <= SHA_IV[i];
      end else if (add_q) begin
        for (int i = 0; i < 8; i++) h_q[i] <= h_q[i] + v_q[i];
      end
      if (start_i) begin
        run_q <= 1'b1;
        rnd_q <= '0;
      end else if (run_q) begin
        rnd_q <= rnd_q + 6'd1;
        if (rnd_q == 6'd63) begin
          run_q <= 1'b0;
          add_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      v_q   <= h_q;
      win_q <= blk_i;
    end else if (run_q) begin
      for (int i = 0; i < 15; i++) win_q[i] <= win_q[i+1];
      win_q[15] <= wnew;
      v_q[7] <= v_q[6];
      v_q[6] <= v_q[5];
      v_q[5] <= v_q[4];
      v_q[4] <= v_q[3] + t1;
      v_q[3] <= v_q[2];
      v_q[2] <= v_q[1];
      v_q[1] <= v_q[0];
      v_q[0] <= t1 + a0 + mj;
    end
  end

  assign done_o = add_q;
  assign hash_o = h_q;

endmodule

>>> src/sha256_hash_chain_appender.sv
// channel | direction | handshake                  | payload
// in      | input     | in_valid_i / in_ready_o    | opcode, data_byte, last_byte, time_stamp
// out     | output    | out_valid_o / out_ready_i  | hash_word .. last_word
//
// A data byte that neither opens nor closes a record passes through the dispatch and byte
// states; opening a record adds the 44 header bytes, every full 64-byte block is compressed
// in the round unit (one SHA-256 round per cycle), closing adds padding plus the final
// block and four output words. Reset leaves the chain unstarted and the block idle.
// Input is taken only when idle; a waiting output word stalls the sequencer, not input.
module sha256_hash_chain_appender (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  opcode_i,
  input  logic [7:0]  data_byte_i,
  input  logic        last_byte_i,
  input  logic [62:0] time_stamp_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [63:0] hash_word_o,
  output logic [1:0]  word_number_o,
  output logic [6:0]  entry_number_o,
  output logic        is_genesis_o,
  output logic        accepted_o,
  output logic        last_word_o
);
  import shc_pkg::*;

  typedef enum logic [9:0] {
    S_IDLE = 10'b0000000001,
    S_DISP = 10'b0000000010,
    S_HDR  = 10'b0000000100,
    S_GTXT = 10'b0000001000,
    S_BYTE = 10'b0000010000,
    S_PAD  = 10'b0000100000,
    S_COMP = 10'b0001000000,
    S_FIN  = 10'b0010000000,
    S_EMIT = 10'b0100000000,
    S_REJ  = 10'b1000000000
  } st_e;

  st_e              st_q, st_d, ret_q, ret_d, nxt;
  logic             started_q, started_d, inrec_q, inrec_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [LEN_W-1:0] len_q, len_d;
  logic [3:0][63:0] prev_q, prev_d;
  logic             pgen_q, pgen_d, popen_q, popen_d, pbyte_q, pbyte_d, pclose_q, pclose_d;
  logic             gmode_q, gmode_d;
  logic [62:0]      ts_q, ts_d;
  logic [7:0]       db_q, db_d;
  logic [5:0]       fill_q, fill_d, sc_q, sc_d;
  logic [TOT_W-1:0] tot_q, tot_d;
  logic [1:0]       wc_q, wc_d;
  blk_t             blk_q;
  logic             wr_en, core_init, core_start, core_done, feeding, out_free;
  logic             start_q, pfirst, plen;
  logic [7:0]       byte_v;
  hash_t            hash;
  logic [351:0]     hdr_vec;
  logic [255:0]     dig;
  logic [63:0]      lenbits;

  logic             ov_q, ov_d, gen_o_q, gen_o_d, acc_q, acc_d, lw_q, lw_d;
  logic [63:0]      hw_q, hw_d;
  logic [1:0]       wn_q, wn_d;
  logic [6:0]       en_q, en_d;

  shc_core u_core (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .init_i  (core_init),
    .start_i (start_q),
    .blk_i   (blk_q),
    .done_o  (core_done),
    .hash_o  (hash)
  );

  always_comb begin
    dig = {prev_q[0], prev_q[1], prev_q[2], prev_q[3]};
    hdr_vec[31:0]    = 32'(cnt_q);
    for (int j = 0; j < 32; j++) hdr_vec[8*(4+j) +: 8] = dig[255-8*j -: 8];
    hdr_vec[351:288] = {1'b0, ts_q};
    lenbits = 64'({tot_q, 3'b000});
  end

  assign feeding  = (st_q == S_HDR) || (st_q == S_GTXT) || (st_q == S_BYTE) || (st_q == S_PAD);
  assign out_free = !ov_q || out_ready_i;

  // pad marker at 56 or above: the length goes into the following block
  assign pfirst = (tot_q[5:0] >= 6'd56) && (({1'b0, sc_q} + {1'b0, tot_q[5:0]}) < 7'd64);
  assign plen   = (fill_q >= 6'd56) && !pfirst;

  always_comb begin
    case (st_q)
      S_HDR:   byte_v = hdr_vec[{sc_q, 3'b000} +: 8];
      S_GTXT:  byte_v = GEN_TEXT[3'(sc_q)];
      S_BYTE:  byte_v = db_q;
      S_PAD: begin
        if (sc_q == 6'd0) byte_v = 8'h80;
        else if (!plen) byte_v = 8'h00;
        else byte_v = lenbits[{~fill_q[2:0], 3'b000} +: 8];
      end
      default: byte_v = 8'h00;
    endcase
    case (st_q)
      S_HDR:   nxt = (sc_q == 6'(HDR_BYTES - 1)) ? (gmode_q ? S_GTXT : S_DISP) : S_HDR;
      S_GTXT:  nxt = (sc_q == 6'(GEN_BYTES - 1)) ? S_PAD : S_GTXT;
      S_BYTE:  nxt = S_DISP;
      S_PAD:   nxt = (sc_q != 6'd0 && plen && fill_q == 6'd63) ? S_FIN : S_PAD;
      default: nxt = S_IDLE;
    endcase
  end

  always_comb begin
    st_d = st_q; ret_d = ret_q; started_d = started_q; inrec_d = inrec_q;
    cnt_d = cnt_q; len_d = len_q; prev_d = prev_q;
    pgen_d = pgen_q; popen_d = popen_q; pbyte_d = pbyte_q; pclose_d = pclose_q;
    gmode_d = gmode_q; ts_d = ts_q; db_d = db_q;
    fill_d = fill_q; sc_d = sc_q; tot_d = tot_q; wc_d = wc_q;
    wr_en = 1'b0; core_init = 1'b0; core_start = 1'b0;
    ov_d = ov_q && !out_ready_i;
    hw_d = hw_q; wn_d = wn_q; en_d = en_q; gen_o_d = gen_o_q; acc_d = acc_q; lw_d = lw_q;

    if (feeding) begin
      wr_en  = 1'b1;
      fill_d = fill_q + 6'd1;
      if (st_q != S_PAD) tot_d = tot_q + TOT_W'(1);
      sc_d = (nxt == st_q) ? ((sc_q == 6'd63) ? sc_q : sc_q + 6'd1) : 6'd0;
      if (fill_q == 6'd63) begin
        core_start = 1'b1;
        ret_d      = nxt;
        st_d       = S_COMP;
      end else begin
        st_d = nxt;
      end
    end

    case (st_q)
      S_IDLE: begin
        if (in_valid_i) begin
          ts_d = time_stamp_i;
          db_d = data_byte_i;
          case (op_e'(opcode_i))
            OP_INIT: begin
              inrec_d = 1'b0; len_d = '0; pgen_d = 1'b1;
              st_d = S_DISP;
            end
            OP_BYTE: begin
              pgen_d = !inrec_q && !started_q; popen_d = !inrec_q;
              pbyte_d = 1'b1; pclose_d = last_byte_i;
              st_d = S_DISP;
            end
            OP_EMPTY: begin
              inrec_d = 1'b0; pgen_d = !started_q; popen_d = 1'b1; pclose_d = 1'b1;
              st_d = S_DISP;
            end
            default: st_d = S_IDLE;
          endcase
        end
      end
      S_DISP: begin
        if (pgen_q) begin
          pgen_d = 1'b0; started_d = 1'b1; cnt_d = '0; prev_d = '0; gmode_d = 1'b1;
          core_init = 1'b1; fill_d = '0; tot_d = '0; sc_d = '0;
          st_d = S_HDR;
        end else if (popen_q) begin
          popen_d = 1'b0; inrec_d = 1'b1; len_d = '0; gmode_d = 1'b0;
          if (cnt_q < CNT_W'(CHAIN_DEPTH)) begin
            core_init = 1'b1; fill_d = '0; tot_d = '0; sc_d = '0;
            st_d = S_HDR;
          end
        end else if (pbyte_q) begin
          pbyte_d = 1'b0;
          if (len_q < LEN_W'(MAX_RECORD_BYTES)) begin
            len_d = len_q + LEN_W'(1);
            if (cnt_q < CNT_W'(CHAIN_DEPTH)) st_d = S_BYTE;
          end
        end else if (pclose_q) begin
          pclose_d = 1'b0; inrec_d = 1'b0; gmode_d = 1'b0; sc_d = '0;
          st_d = (cnt_q < CNT_W'(CHAIN_DEPTH)) ? S_PAD : S_REJ;
        end else begin
          st_d = S_IDLE;
        end
      end
      S_COMP: begin
        if (core_done) st_d = ret_q;
      end
      S_FIN: begin
        for (int i = 0; i < 4; i++) prev_d[i] = {hash[2*i], hash[2*i+1]};
        wc_d = '0;
        st_d = S_EMIT;
      end
      S_EMIT: begin
        if (out_free) begin
          ov_d = 1'b1; hw_d = prev_q[wc_q]; wn_d = wc_q; en_d = cnt_q[6:0];
          gen_o_d = gmode_q; acc_d = 1'b1;
          lw_d = (wc_q == 2'd3) && !(gmode_q && pclose_q);
          wc_d = wc_q + 2'd1;
          if (wc_q == 2'd3) begin
            cnt_d = cnt_q + CNT_W'(1);
            st_d  = S_DISP;
          end
        end
      end
      S_REJ: begin
        if (out_free) begin
          ov_d = 1'b1; hw_d = '0; wn_d = '0; en_d = '0;
          gen_o_d = 1'b0; acc_d = 1'b0; lw_d = 1'b1;
          st_d = S_DISP;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= S_IDLE; ret_q <= S_IDLE;
      started_q <= 1'b0; inrec_q <= 1'b0; cnt_q <= '0; len_q <= '0; prev_q <= '0;
      pgen_q <= 1'b0; popen_q <= 1'b0; pbyte_q <= 1'b0; pclose_q <= 1'b0;
      gmode_q <= 1'b0; fill_q <= '0; sc_q <= '0; tot_q <= '0; wc_q <= '0; ov_q <= 1'b0;
      start_q <= 1'b0;
    end else begin
      st_q <= st_d; ret_q <= ret_d;
      started_q <= started_d; inrec_q <= inrec_d; cnt_q <= cnt_d; len_q <= len_d;
      prev_q <= prev_d;
      pgen_q <= pgen_d; popen_q <= popen_d; pbyte_q <= pbyte_d; pclose_q <= pclose_d;
      gmode_q <= gmode_d; fill_q <= fill_d; sc_q <= sc_d; tot_q <= tot_d; wc_q <= wc_d;
      ov_q <= ov_d;
      start_q <= core_start;
    end
  end

  always_ff @(posedge clk_i) begin
    ts_q <= ts_d; db_q <= db_d;
    hw_q <= hw_d; wn_q <= wn_d; en_q <= en_d; gen_o_q <= gen_o_d; acc_q <= acc_d;
    lw_q <= lw_d;
    if (wr_en) blk_q[fill_q[5:2]][{~fill_q[1:0], 3'b000} +: 8] <= byte_v;
  end

  assign in_ready_o     = (st_q == S_IDLE);
  assign out_valid_o    = ov_q;
  assign hash_word_o    = hw_q;
  assign word_number_o  = wn_q;
  assign entry_number_o = en_q;
  assign is_genesis_o   = gen_o_q;
  assign accepted_o     = acc_q;
  assign last_word_o    = lw_q;

endmodule
